// ===== src/spe_pkg.sv =====
// shared types and codes for the sparse polynomial evaluator
`timescale 1ns / 1ps

package spe_pkg;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_EVAL   = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_POW,
    ST_POW_WB,
    ST_ACC,
    ST_DONE
  } state_e;

endpackage

// ===== src/sparse_polynomial_evaluator_top.sv =====
// sparse polynomial evaluator: term table in memory, shared multiplier, result register
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  input   | in_valid_i / in_ready_o | operation_i, coefficient_i, exponent_i, point_i
//  output  | out_valid_o/ out_ready_i| value_o, status_o, stored_terms_o
//
// an append holds the block for accept, then result load; an evaluate for accept, then
// read, load, power steps and accumulate per stored term, then result load; the result
// shows the cycle after. the single 32x32 multiplier sets the time: each power step is
// multiply, then shift and saturate; each term adds read, load, multiply and accumulate
// reset clears state, term count and output valid; term memory needs no clearing pass
// one item at a time; a new item is taken while the previous result waits in the
// output register, and a finished result waits for that register to free up
`timescale 1ns / 1ps

module sparse_polynomial_evaluator_top #(
  parameter int MAX_TERMS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic signed [31:0] coefficient_i,
  input  logic [4:0]         exponent_i,
  input  logic signed [31:0] point_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic [1:0]         status_o,
  output logic [6:0]         stored_terms_o
);

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;

  spe_pkg::state_e state_q, state_d;

  // term memory: {coefficient, exponent}
  logic [36:0] mem [MAX_TERMS];
  logic [36:0] rd_data_q;
  logic        rd_en, mem_we;

  logic [CW-1:0]      count_q, idx_q;
  logic signed [31:0] x_q, sum_q, pw_q, res_value_q;
  logic [4:0]         ecnt_q;
  logic               sat_q;
  logic [1:0]         res_status_q;
  logic signed [63:0] prod_q;
  logic               out_load, accept, full;

  logic signed [31:0] rd_coef;
  logic [4:0]         rd_exp;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_sh;
  logic signed [31:0] prod_sat;
  logic               prod_ovf;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic               sum_ovf;
  logic               last_term;
  logic [CW+6:0]      count_ext;

  assign accept  = in_valid_i && in_ready_o;
  assign full    = (count_q == CW'(MAX_TERMS));
  assign rd_coef = rd_data_q[36:5];
  assign rd_exp  = rd_data_q[4:0];
  assign last_term = (idx_q + CW'(1)) == count_q;

  // shared multiplier: power step while exponent remains, then coefficient times power
  assign mul_a = (ecnt_q != 5'd0) ? pw_q : rd_coef;
  assign mul_b = (ecnt_q != 5'd0) ? x_q  : pw_q;

  assign prod_sh  = prod_q >>> FRAC_BITS;
  assign prod_ovf = (prod_sh > MAX32) || (prod_sh < MIN32);
  assign prod_sat = (prod_sh > MAX32) ? 32'sh7fffffff :
                    (prod_sh < MIN32) ? 32'sh80000000 : prod_sh[31:0];

  assign sum_wide = {sum_q[31], sum_q} + {prod_sat[31], prod_sat};
  assign sum_ovf  = sum_wide[32] != sum_wide[31];
  assign sum_sat  = !sum_ovf ? sum_wide[31:0] :
                    (sum_wide[32] ? 32'sh80000000 : 32'sh7fffffff);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spe_pkg::ST_IDLE: begin
        if (accept) begin
          if (operation_i == spe_pkg::OP_EVAL && count_q != '0) begin
            state_d = spe_pkg::ST_READ;
          end else begin
            state_d = spe_pkg::ST_DONE;
          end
        end
      end
      spe_pkg::ST_READ:   state_d = spe_pkg::ST_LOAD;
      spe_pkg::ST_LOAD:   state_d = spe_pkg::ST_POW;
      spe_pkg::ST_POW: begin
        state_d = (ecnt_q != 5'd0) ? spe_pkg::ST_POW_WB : spe_pkg::ST_ACC;
      end
      spe_pkg::ST_POW_WB: state_d = spe_pkg::ST_POW;
      spe_pkg::ST_ACC: begin
        state_d = last_term ? spe_pkg::ST_DONE : spe_pkg::ST_READ;
      end
      spe_pkg::ST_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          state_d = spe_pkg::ST_IDLE;
        end
      end
      default: state_d = spe_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      spe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        mem_we     = in_valid_i && operation_i == spe_pkg::OP_APPEND && !full;
      end
      spe_pkg::ST_READ: rd_en = 1'b1;
      spe_pkg::ST_DONE: out_load = !out_valid_o || out_ready_i;
      default: ;
    endcase
  end

  // reads and writes never overlap: one item is in flight at a time
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[AW-1:0]] <= {coefficient_i, exponent_i};
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spe_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mem_we) begin
        count_q <= count_q + CW'(1);
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      spe_pkg::ST_IDLE: begin
        if (accept) begin
          x_q          <= point_i;
          sum_q        <= '0;
          sat_q        <= 1'b0;
          idx_q        <= '0;
          res_value_q  <= '0;
          res_status_q <= (operation_i == spe_pkg::OP_APPEND && full) ?
                          spe_pkg::STATUS_FULL : spe_pkg::STATUS_OK;
        end
      end
      spe_pkg::ST_LOAD: begin
        pw_q   <= ONE;
        ecnt_q <= rd_exp;
      end
      spe_pkg::ST_POW: begin
        prod_q <= mul_a * mul_b;
      end
      spe_pkg::ST_POW_WB: begin
        pw_q   <= prod_sat;
        sat_q  <= sat_q | prod_ovf;
        ecnt_q <= ecnt_q - 5'd1;
      end
      spe_pkg::ST_ACC: begin
        sum_q        <= sum_sat;
        idx_q        <= idx_q + CW'(1);
        res_value_q  <= sum_sat;
        res_status_q <= (sat_q | prod_ovf | sum_ovf) ? spe_pkg::STATUS_SAT
                                                     : spe_pkg::STATUS_OK;
        sat_q        <= sat_q | prod_ovf | sum_ovf;
      end
      default: ;
    endcase
  end

  assign count_ext = {7'd0, count_q};

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_o        <= res_value_q;
      status_o       <= res_status_q;
      stored_terms_o <= count_ext[6:0];
    end
  end

endmodule
